### rtl/core/nearest_palette_color_top_defines.svh
// Assertion macros for the RTL of the nearest palette color block
`ifndef NEAREST_PALETTE_COLOR_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define NPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define NPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/npc_pkg.sv
package npc_pkg;

    // Palette geometry and field widths
    localparam int PAL_DEPTH = 16;
    localparam int IDX_W     = 4;
    localparam int CHAN_W    = 8;
    localparam int SQ_W      = 2 * CHAN_W;
    localparam int DIST_W    = 18;
    localparam int COUNT_W   = 5;
    localparam int ENTRY_W   = 3 * CHAN_W;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index, taken from paddr[2]
    localparam logic REG_PALETTE_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    // Item operation codes
    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load_wr;
        logic             capture;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             first;
        logic             last;
        logic             out_load;
    } npc_cmd_t;

    // Last searched slot for a programmed count: zero counts as one,
    // large counts saturate at the palette depth
    function automatic logic [IDX_W-1:0] last_slot(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] n;
        n = count;
        if (count == '0)
        begin
            n = COUNT_W'(1);
        end
        else if (count > COUNT_W'(PAL_DEPTH))
        begin
            n = COUNT_W'(PAL_DEPTH);
        end
        return IDX_W'(n - COUNT_W'(1));
    endfunction

    // Magnitude of the difference of two channels
    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

### rtl/core/npc_if.sv
// Input channel: one load or classify transaction
interface npc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [npc_pkg::IDX_W-1:0]     entry_index;
    logic [npc_pkg::CHAN_W-1:0]    red;
    logic [npc_pkg::CHAN_W-1:0]    green;
    logic [npc_pkg::CHAN_W-1:0]    blue;

    modport source (output valid, output op, output entry_index, output red,
                    output green, output blue, input ready);
    modport sink (input valid, input op, input entry_index, input red,
                  input green, input blue, output ready);
endinterface

// Output channel: one classification result per classify transaction
interface npc_out_if;
    logic                          valid;
    logic                          ready;
    logic [npc_pkg::IDX_W-1:0]     best_index;
    logic [npc_pkg::CHAN_W-1:0]    best_red;
    logic [npc_pkg::CHAN_W-1:0]    best_green;
    logic [npc_pkg::CHAN_W-1:0]    best_blue;
    logic [npc_pkg::DIST_W-1:0]    best_distance;

    modport source (output valid, output best_index, output best_red,
                    output best_green, output best_blue, output best_distance,
                    input ready);
    modport sink (input valid, input best_index, input best_red,
                  input best_green, input best_blue, input best_distance,
                  output ready);
endinterface

### rtl/core/nearest_palette_color_top.sv
// Nearest palette color: maps RGB pixels to the closest of up to 16 stored
// palette entries by squared Euclidean distance.
// Input channel in_ch (valid/ready): op selects a load, which writes entry
// entry_index with red/green/blue, or a classify of the pixel red/green/blue.
// Output channel out_ch (valid/ready): one result per classify transaction with
// the winning slot, its RGB value and the distance; ties go to the lowest slot.
// APB port: palette_count at address 0 sets how many slots are searched
// (0 counts as 1, values above 16 as 16). Write it only while the block is idle.
// Throughput: a classify scans one palette entry per cycle through the single
// read port of the palette memory; no new transaction is accepted until the
// scan has drained and its result has moved to the output register.
// A pending result sits in an output register; a load or the next classify is
// accepted while it waits, and a finished classify holds in the datapath until
// the receiver takes the previous result.
// Reset clears the control state and sets palette_count to 1; palette entries
// are undefined until loaded.
module nearest_palette_color_top (
    input  logic                          clk,
    input  logic                          rst_n,
    npc_in_if.sink                        in_ch,
    npc_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [npc_pkg::APB_AW-1:0]    paddr,
    input  logic [npc_pkg::APB_DW-1:0]    pwdata,
    output logic [npc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    logic [npc_pkg::COUNT_W-1:0] count_reg;
    npc_pkg::npc_cmd_t           cmd;
    logic                        done;
    logic                        cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == npc_pkg::REG_PALETTE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= npc_pkg::COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            count_reg <= pwdata[npc_pkg::COUNT_W-1:0];
        end
    end

    // Read back
    assign prdata = (paddr[2] == npc_pkg::REG_PALETTE_COUNT)
                  ? npc_pkg::APB_DW'(count_reg) : '0;

    npc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_op         (in_ch.op),
        .in_ready      (in_ch.ready),
        .palette_count (count_reg),
        .done          (done),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .cmd           (cmd)
    );

    npc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .entry_index   (in_ch.entry_index),
        .red           (in_ch.red),
        .green         (in_ch.green),
        .blue          (in_ch.blue),
        .done          (done),
        .best_index    (out_ch.best_index),
        .best_red      (out_ch.best_red),
        .best_green    (out_ch.best_green),
        .best_blue     (out_ch.best_blue),
        .best_distance (out_ch.best_distance)
    );

endmodule

### rtl/core/npc_dp.sv
module npc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  npc_pkg::npc_cmd_t             cmd,
    input  logic [npc_pkg::IDX_W-1:0]     entry_index,
    input  logic [npc_pkg::CHAN_W-1:0]    red,
    input  logic [npc_pkg::CHAN_W-1:0]    green,
    input  logic [npc_pkg::CHAN_W-1:0]    blue,
    output logic                          done,
    output logic [npc_pkg::IDX_W-1:0]     best_index,
    output logic [npc_pkg::CHAN_W-1:0]    best_red,
    output logic [npc_pkg::CHAN_W-1:0]    best_green,
    output logic [npc_pkg::CHAN_W-1:0]    best_blue,
    output logic [npc_pkg::DIST_W-1:0]    best_distance
);

    localparam int CW = npc_pkg::CHAN_W;

    // Palette memory and read stage
    logic [npc_pkg::ENTRY_W-1:0] pal_mem [npc_pkg::PAL_DEPTH];
    logic [npc_pkg::ENTRY_W-1:0] rd_data_reg;

    // Pixel under classification
    logic [CW-1:0] pix_r_reg, pix_g_reg, pix_b_reg;

    // Stage 1 tags (travel with the read data)
    logic                      s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [npc_pkg::IDX_W-1:0] s1_idx_reg;

    // Stage 2: squared channel differences
    logic                      s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [npc_pkg::IDX_W-1:0] s2_idx_reg;
    logic [npc_pkg::SQ_W-1:0]  sq_r_reg, sq_g_reg, sq_b_reg;
    logic [npc_pkg::ENTRY_W-1:0] s2_rgb_reg;
    logic [CW-1:0]             dr, dg, db;

    // Running best
    logic [npc_pkg::DIST_W-1:0]  cand_dist;
    logic                        take;
    logic [npc_pkg::DIST_W-1:0]  best_dist_reg;
    logic [npc_pkg::IDX_W-1:0]   best_idx_reg;
    logic [npc_pkg::ENTRY_W-1:0] best_rgb_reg;
    logic                        done_reg;

    // Result register
    logic [npc_pkg::IDX_W-1:0]   out_idx_reg;
    logic [npc_pkg::ENTRY_W-1:0] out_rgb_reg;
    logic [npc_pkg::DIST_W-1:0]  out_dist_reg;

    // Write one entry on a load, read one entry per scan cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && ({1'b0, entry_index} < (npc_pkg::IDX_W + 1)'(npc_pkg::PAL_DEPTH)))
        begin
            pal_mem[entry_index] <= {red, green, blue};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= pal_mem[cmd.rd_addr];
        end
    end

    // Channel differences of the entry just read
    assign dr = npc_pkg::abs_diff(pix_r_reg, rd_data_reg[3*CW-1:2*CW]);
    assign dg = npc_pkg::abs_diff(pix_g_reg, rd_data_reg[2*CW-1:CW]);
    assign db = npc_pkg::abs_diff(pix_b_reg, rd_data_reg[CW-1:0]);

    // Distance and replacement test; ties keep the earlier slot
    assign cand_dist = npc_pkg::DIST_W'(sq_r_reg) + npc_pkg::DIST_W'(sq_g_reg)
                     + npc_pkg::DIST_W'(sq_b_reg);
    assign take = s2_valid_reg && (s2_first_reg || (cand_dist < best_dist_reg));

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_r_reg <= red;
            pix_g_reg <= green;
            pix_b_reg <= blue;
        end
        s1_idx_reg <= cmd.rd_addr;
        s2_idx_reg <= s1_idx_reg;
        s2_rgb_reg <= rd_data_reg;
        sq_r_reg   <= npc_pkg::SQ_W'(dr * dr);
        sq_g_reg   <= npc_pkg::SQ_W'(dg * dg);
        sq_b_reg   <= npc_pkg::SQ_W'(db * db);
        if (take)
        begin
            best_dist_reg <= cand_dist;
            best_idx_reg  <= s2_idx_reg;
            best_rgb_reg  <= s2_rgb_reg;
        end
        if (cmd.out_load)
        begin
            out_idx_reg  <= best_idx_reg;
            out_rgb_reg  <= best_rgb_reg;
            out_dist_reg <= best_dist_reg;
        end
    end

    // Pipeline control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en;
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last;
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            done_reg     <= s2_valid_reg && s2_last_reg;
        end
    end

    assign done          = done_reg;
    assign best_index    = out_idx_reg;
    assign best_red      = out_rgb_reg[3*CW-1:2*CW];
    assign best_green    = out_rgb_reg[2*CW-1:CW];
    assign best_blue     = out_rgb_reg[CW-1:0];
    assign best_distance = out_dist_reg;

endmodule

### rtl/core/npc_ctrl.sv
`include "nearest_palette_color_top_defines.svh"

module npc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_op,
    output logic                          in_ready,
    input  logic [npc_pkg::COUNT_W-1:0]   palette_count,
    input  logic                          done,
    output logic                          out_valid,
    input  logic                          out_ready,
    output npc_pkg::npc_cmd_t             cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t                    state_reg, state_next;
    logic [npc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [npc_pkg::IDX_W-1:0] last_reg, last_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      accept;
    logic                      out_free;
    logic                      classify;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign classify = (in_op == npc_pkg::OP_CLASSIFY);
    assign out_free = !out_valid_reg || out_ready;

    // Commands to the datapath
    always_comb
    begin
        cmd          = '0;
        cmd.load_wr  = accept && (in_op == npc_pkg::OP_LOAD);
        cmd.capture  = accept && classify;
        cmd.rd_en    = (state_reg == ST_SCAN);
        cmd.rd_addr  = idx_reg;
        cmd.first    = (state_reg == ST_SCAN) && (idx_reg == '0);
        cmd.last     = (state_reg == ST_SCAN) && (idx_reg == last_reg);
        cmd.out_load = (((state_reg == ST_DRAIN) && done) || (state_reg == ST_HOLD))
                     && out_free;
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && classify)
                begin
                    idx_next   = '0;
                    last_next  = npc_pkg::last_slot(palette_count);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A new result never overwrites one that is still pending
    `NPC_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_reg || out_ready), "result overwritten")
    // A classify transaction starts the scan in the next cycle
    `NPC_ASSERT(a_classify_scan, (accept && classify) |=> (state_reg == ST_SCAN), "scan not started")
    // The datapath finishes only while the controller drains
    `NPC_ASSERT(a_done_drain, done |-> (state_reg == ST_DRAIN), "unexpected done")

endmodule
